@@ sv/usx_pkg.sv @@
package usx_pkg;

  localparam int SEED_BITS    = 30;
  localparam int SEED_LETTERS = 15;
  localparam int LETTER_MAX   = 8;
  localparam int RUN_W        = 5;
  localparam int RUN_MAX      = 31;
  localparam int BEST_W       = 23;
  localparam int EXTENT_W     = 17;
  localparam int BEST_MAX     = 8388607;

  localparam int DEF_MAX_EXTENSION = 65535;
  localparam int DEF_LETTER_BITS   = 4;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  typedef enum logic [2:0] {
    REG_MATCH      = 3'd0,
    REG_MISMATCH   = 3'd1,
    REG_XDROP      = 3'd2,
    REG_INVALID    = 3'd3,
    REG_SPAN       = 3'd4,
    REG_REDUNDANCY = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [6:0]        match_score;
    logic signed [7:0] mismatch_score;
    logic [9:0]        xdrop_limit;
    logic [3:0]        invalid_letter;
    logic [3:0]        seed_span;
    logic              redundancy_check;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    match_score:      7'd1,
    mismatch_score:   -8'sd3,
    xdrop_limit:      10'd20,
    invalid_letter:   4'd4,
    seed_span:        4'd11,
    redundancy_check: 1'b1
  };

  typedef struct packed {
    logic                  action;
    logic                  first;
    logic [SEED_BITS-1:0]  seed_code;
    logic [LETTER_MAX-1:0] subject_letter;
    logic [LETTER_MAX-1:0] query_letter;
    logic                  letter_valid;
    logic                  last;
  } item_t;

  typedef struct packed {
    logic [BEST_W-1:0]   best_score;
    logic [EXTENT_W-1:0] extent;
    logic                already_seen;
  } result_t;

endpackage

@@ sv/ungapped_xdrop_seed_extension_core.sv @@
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  tdata: seed, letters; tuser: flags; tlast: last pair
// m_*      out  m_tvalid/m_tready  tdata: best score, extent; tuser: already seen
// apb      in   psel/penable       register i at byte address 4*i, pready tied high
//
// one letter pair per cycle while the output is not stalled; each pair is held in
// the input register, and its result, if any, is registered in the output register
// the score, best and rolling-code update is a single add, compare and shift step
// a stalled output holds the pipe; the input still takes a transfer while its
// register is empty
// rst is synchronous; no clearing pass, the block is ready right after reset
module ungapped_xdrop_seed_extension_core import usx_pkg::*; #(
  parameter int  MAX_EXTENSION = DEF_MAX_EXTENSION,
  parameter int  LETTER_BITS   = DEF_LETTER_BITS,
  localparam int IN_W          = ((SEED_BITS + 2 * LETTER_BITS + 7) / 8) * 8,
  localparam int OUT_W         = ((BEST_W + EXTENT_W + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst,

  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [IN_W-1:0]   s_tdata,   // seed_code, subject_letter, query_letter
  input  logic [2:0]        s_tuser,   // action, first, letter_valid
  input  logic              s_tlast,   // last

  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [OUT_W-1:0]  m_tdata,   // best_score, extent
  output logic [0:0]        m_tuser,   // already_seen

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  item_t   in_item;
  logic    in_valid;
  logic    advance, fire, core_valid;
  result_t core_res, out_res;

  usx_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;
  assign fire     = in_valid && advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.action         <= s_tuser[0];
      in_item.first          <= s_tuser[1];
      in_item.letter_valid   <= s_tuser[2];
      in_item.last           <= s_tlast;
      in_item.seed_code      <= s_tdata[SEED_BITS-1:0];
      in_item.subject_letter <= LETTER_MAX'(s_tdata[SEED_BITS +: LETTER_BITS]);
      in_item.query_letter   <= LETTER_MAX'(s_tdata[SEED_BITS + LETTER_BITS +: LETTER_BITS]);
    end
  end

  usx_core #(
    .MAX_EXTENSION (MAX_EXTENSION)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .step      (fire),
    .item      (in_item),
    .res_valid (core_valid),
    .res       (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= core_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_valid) begin
      out_res <= core_res;
    end
  end

  assign m_tdata = OUT_W'({out_res.extent, out_res.best_score});
  assign m_tuser = out_res.already_seen;

endmodule

@@ sv/usx_cfg.sv @@
module usx_cfg import usx_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr) begin
      case (idx)
        REG_MATCH:      cfg.match_score      <= pwdata[6:0];
        REG_MISMATCH:   cfg.mismatch_score   <= $signed(pwdata[7:0]);
        REG_XDROP:      cfg.xdrop_limit      <= pwdata[9:0];
        REG_INVALID:    cfg.invalid_letter   <= pwdata[3:0];
        REG_SPAN:       cfg.seed_span        <= pwdata[3:0];
        REG_REDUNDANCY: cfg.redundancy_check <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MATCH:      prdata = CFG_DW'(cfg.match_score);
      REG_MISMATCH:   prdata = CFG_DW'($unsigned(cfg.mismatch_score));
      REG_XDROP:      prdata = CFG_DW'(cfg.xdrop_limit);
      REG_INVALID:    prdata = CFG_DW'(cfg.invalid_letter);
      REG_SPAN:       prdata = CFG_DW'(cfg.seed_span);
      REG_REDUNDANCY: prdata = CFG_DW'(cfg.redundancy_check);
      default:        prdata = '0;
    endcase
  end

endmodule

@@ sv/usx_core.sv @@
module usx_core import usx_pkg::*; #(
  parameter int MAX_EXTENSION = DEF_MAX_EXTENSION
) (
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    step,
  input  item_t   item,
  output logic    res_valid,
  output result_t res
);

  localparam int POS_W   = $clog2(MAX_EXTENSION + 2);
  localparam int SCORE_W = $clog2(128 * (MAX_EXTENSION + 18)) + 1;

  logic signed [SCORE_W-1:0] running_score, best_so_far;
  logic [POS_W-1:0]          best_position, position;
  logic [RUN_W-1:0]          match_run;
  logic [SEED_BITS-1:0]      rolling_code, start_code;
  logic                      direction, stopped, seen_flag;

  logic signed [SCORE_W-1:0] running_score_next, best_so_far_next;
  logic [POS_W-1:0]          best_position_next, position_next;
  logic [RUN_W-1:0]          match_run_next;
  logic [SEED_BITS-1:0]      rolling_code_next, start_code_next;
  logic                      direction_next, stopped_next, seen_flag_next;

  // start-of-extension values, or the held state
  logic signed [SCORE_W-1:0] b_run, b_best;
  logic [POS_W-1:0]          b_pos, b_bpos;
  logic [RUN_W-1:0]          b_mrun;
  logic [SEED_BITS-1:0]      b_roll;
  logic                      open;
  logic [10:0]               start_score;

  logic [SEED_BITS-1:0]      shr, shl, roll_r, roll_l;
  logic                      is_match, finish;
  logic signed [7:0]         delta;
  logic signed [SCORE_W:0]   drop;

  assign start_score = 11'(cfg.seed_span) * 11'(cfg.match_score);
  assign shr = b_roll >> 2;
  assign shl = b_roll << 2;

  always_comb begin
    if (item.first) begin
      b_run  = SCORE_W'($signed({1'b0, start_score}));
      b_best = SCORE_W'($signed({1'b0, start_score}));
      b_pos  = item.action ? '0 : POS_W'(cfg.seed_span);
      b_bpos = item.action ? '0 : POS_W'(cfg.seed_span);
      b_mrun = RUN_W'(cfg.seed_span);
      b_roll = item.seed_code;
      open   = 1'b1;
    end else begin
      b_run  = running_score;
      b_best = best_so_far;
      b_pos  = position;
      b_bpos = best_position;
      b_mrun = match_run;
      b_roll = rolling_code;
      open   = !stopped;
    end
  end

  // next rolling code, one 2-bit letter slot at a time, masked to the span
  always_comb begin
    for (int i = 0; i < SEED_LETTERS; i++) begin
      if (i < int'(cfg.seed_span)) begin
        roll_r[2*i +: 2] = shr[2*i +: 2] |
                           ((i + 1 == int'(cfg.seed_span)) ? item.subject_letter[1:0] : 2'b00);
        roll_l[2*i +: 2] = shl[2*i +: 2] | ((i == 0) ? item.subject_letter[1:0] : 2'b00);
      end else begin
        roll_r[2*i +: 2] = 2'b00;
        roll_l[2*i +: 2] = 2'b00;
      end
    end
  end

  assign is_match = (item.subject_letter == item.query_letter) &&
                    (item.subject_letter < LETTER_MAX'(cfg.invalid_letter));
  assign delta = is_match ? $signed({1'b0, cfg.match_score}) : cfg.mismatch_score;

  always_comb begin
    direction_next     = item.first ? item.action : direction;
    start_code_next    = item.first ? item.seed_code : start_code;
    seen_flag_next     = item.first ? 1'b0 : seen_flag;
    running_score_next = b_run;
    best_so_far_next   = b_best;
    best_position_next = b_bpos;
    position_next      = b_pos;
    match_run_next     = b_mrun;
    rolling_code_next  = b_roll;
    drop               = '0;
    finish             = 1'b0;
    if (open) begin
      if (!item.letter_valid) begin
        finish = item.first || item.last;
      end else begin
        rolling_code_next  = direction_next ? roll_l : roll_r;
        running_score_next = b_run + SCORE_W'(delta);
        position_next      = b_pos + POS_W'(1);
        if (is_match) begin
          match_run_next = (b_mrun != RUN_W'(RUN_MAX)) ? b_mrun + RUN_W'(1) : b_mrun;
          if (running_score_next > b_best) begin
            best_so_far_next   = running_score_next;
            best_position_next = b_pos;
          end
          if (cfg.redundancy_check && (match_run_next >= RUN_W'(cfg.seed_span)) &&
              (rolling_code_next < start_code_next)) begin
            seen_flag_next = 1'b1;
            finish         = 1'b1;
          end
        end else begin
          match_run_next = '0;
        end
        drop = (SCORE_W+1)'(best_so_far_next) - (SCORE_W+1)'(running_score_next);
        if (drop > $signed({1'b0, cfg.xdrop_limit})) finish = 1'b1;
        if (item.last) finish = 1'b1;
        if (b_pos >= POS_W'(MAX_EXTENSION)) finish = 1'b1;
      end
    end
    stopped_next = finish ? 1'b1 : (item.first ? 1'b0 : stopped);
  end

  assign res_valid = step && finish;
  assign res.best_score = (int'(best_so_far_next) > BEST_MAX) ? BEST_W'(BEST_MAX)
                                                               : BEST_W'(best_so_far_next);
  assign res.extent       = EXTENT_W'({1'b0, best_position_next} + (POS_W+1)'(1));
  assign res.already_seen = seen_flag_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      running_score <= '0;
      best_so_far   <= '0;
      best_position <= '0;
      position      <= '0;
      match_run     <= '0;
      rolling_code  <= '0;
      start_code    <= '0;
      direction     <= 1'b0;
      stopped       <= 1'b1;
      seen_flag     <= 1'b0;
    end else if (step) begin
      running_score <= running_score_next;
      best_so_far   <= best_so_far_next;
      best_position <= best_position_next;
      position      <= position_next;
      match_run     <= match_run_next;
      rolling_code  <= rolling_code_next;
      start_code    <= start_code_next;
      direction     <= direction_next;
      stopped       <= stopped_next;
      seen_flag     <= seen_flag_next;
    end
  end

  a_best_above_running: assert property (@(posedge clk) disable iff (rst)
    best_so_far >= running_score)
    else $error("running score above best");

  a_best_pos_order: assert property (@(posedge clk) disable iff (rst)
    best_position <= position)
    else $error("best position beyond current position");

  a_seen_ends: assert property (@(posedge clk) disable iff (rst)
    seen_flag |-> stopped)
    else $error("already-seen extension still open");

  a_result_stops: assert property (@(posedge clk) disable iff (rst)
    res_valid |=> stopped)
    else $error("extension open after its result");

endmodule
